// ===== hw/rtl/cursor_array_list_engine_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef CURSOR_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

// checked only while out of reset
`define CALE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in and out of reset
`define CALE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cale_pkg.sv =====
// shared constants and types of the cursor array list engine
package cale_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int MODE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_GET   = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/cale_ram.sv =====
// generic single write port, single read port ram with registered read
module cale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cursor_array_list_engine_unit.sv =====
// top level of the cursor array list engine: sequencer, list state and config register
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_ready  | in_mode, in_data_in
//  out     | out_valid / out_ready| out_ok, out_data_out
//  cfg     | psel, penable, pready| pwrite, paddr, pwdata, prdata
//
// insert, next, back and refused requests: go from idle to the finish state, which registers the result
// get: passes through the get state for the registered ram read at the cursor
// delete: the shift state moves each later entry down (up to DEPTH-1), one ram write a cycle
// in_ready is high only in the idle state; a held result stalls the sequencer at its end
// reset is synchronous; entries are not cleared and there is no clearing pass
module cursor_array_list_engine_unit #(
  parameter int DEPTH        = cale_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = cale_pkg::ELEMENT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cale_pkg::MODE_W-1:0]  in_mode,
  input  logic [cale_pkg::DATA_W-1:0]  in_data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [cale_pkg::DATA_W-1:0]  out_data_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cale_pkg::APB_AW-1:0]  paddr,
  input  logic [cale_pkg::APB_DW-1:0]  pwdata,
  output logic [cale_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import cale_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        cursor_r, cursor_nxt;
  logic [IDX_W-1:0]        ptr_r, ptr_nxt;
  logic [CAP_W-1:0]        cap_r, cap_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic [DATA_W-1:0]       res_data_r, res_data_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [DATA_W-1:0]       out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ELEMENT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  logic                    accept;
  logic                    not_empty;
  logic                    has_room;
  logic [CNT_W-1:0]        cur_inc;
  logic [CNT_W-1:0]        ptr_inc;
  logic [CNT_W-1:0]        ptr_inc2;
  logic                    cfg_wr;
  logic                    cfg_idx;

  cale_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready     = (state_r == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_data_out = out_data_r;

  assign not_empty = (count_r != '0);
  assign has_room  = (CMP_W'(count_r) < CMP_W'(cap_r)) && (CMP_W'(count_r) < DEPTH_CMP);
  assign cur_inc   = CNT_W'(cursor_r) + CNT_W'(1);
  assign ptr_inc   = CNT_W'(ptr_r) + CNT_W'(1);
  assign ptr_inc2  = ptr_inc + CNT_W'(1);

  // config register
  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == REG_CAPACITY) ? APB_DW'(cap_r) : '0;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && (cfg_idx == REG_CAPACITY)) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    ptr_nxt       = ptr_r;
    res_ok_nxt    = res_ok_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = cursor_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt   = 1'b0;
          res_data_nxt = '0;
          state_nxt    = ST_FIN;
          case (in_mode)
            MODE_INSERT: begin
              if (has_room) begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(count_r);
                ram_wdata  = ELEMENT_BITS'(in_data_in);
                count_nxt  = count_r + CNT_W'(1);
                res_ok_nxt = 1'b1;
              end
            end
            MODE_GET: begin
              if (not_empty) begin
                res_ok_nxt = 1'b1;
                state_nxt  = ST_GET;
              end
            end
            MODE_NEXT: begin
              if (not_empty && (cur_inc < count_r)) begin
                cursor_nxt = cursor_r + IDX_W'(1);
                res_ok_nxt = 1'b1;
              end
            end
            MODE_BACK: begin
              if (not_empty && (cursor_r != '0)) begin
                cursor_nxt = cursor_r - IDX_W'(1);
                res_ok_nxt = 1'b1;
              end
            end
            MODE_DELETE: begin
              if (not_empty) begin
                res_ok_nxt = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
                if (cursor_r != '0) begin
                  cursor_nxt = cursor_r - IDX_W'(1);
                end
                ptr_nxt   = cursor_r;
                ram_raddr = IDX_W'(cur_inc);
                if (cur_inc < count_r) begin
                  state_nxt = ST_SHIFT;
                end
              end
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_GET: begin
        res_data_nxt = DATA_W'(ram_rdata);
        state_nxt    = ST_FIN;
      end
      ST_SHIFT: begin
        // count already holds the shortened length
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
        ram_raddr = IDX_W'(ptr_inc2);
        ptr_nxt   = IDX_W'(ptr_inc);
        if (!(ptr_inc < count_r)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_data_nxt  = res_data_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    res_ok_r   <= res_ok_nxt;
    res_data_r <= res_data_nxt;
    out_ok_r   <= out_ok_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/cale_checker.sv =====
// port level checker of the cursor array list engine and its bind
`include "cursor_array_list_engine_unit_assert.svh"

module cale_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic [cale_pkg::DATA_W-1:0] out_data_out
);

  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_data_out);
  endproperty

  property p_refused_zero;
    out_valid && !out_ok |-> out_data_out == '0;
  endproperty

  property p_busy_after_accept;
    in_valid && in_ready |=> !in_ready;
  endproperty

  property p_reset_quiet;
    !rst_n |=> !out_valid;
  endproperty

  `CALE_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")
  `CALE_ASSERT(a_refused_zero, p_refused_zero, "refused request carries nonzero data")
  `CALE_ASSERT(a_busy_after_accept, p_busy_after_accept, "new request taken while busy")
  `CALE_ASSERT_RST(a_reset_quiet, p_reset_quiet, "result shown right after reset")

endmodule

bind cursor_array_list_engine_unit cale_checker u_cale_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_ok       (out_ok),
  .out_data_out (out_data_out)
);
